### design/rvv_pkg.sv
// Shared types and constants for the realized variance / volatility unit.
`timescale 1ns / 1ps

package rvv_pkg;

    localparam int SUM_W      = 64;  // Q32.32 sum of squared differences
    localparam int TS_W       = 32;  // time span, Q16.16
    localparam int RES_W      = 48;  // result, Q32.16
    localparam int MAG_W      = 32;  // difference magnitude fed to the multiplier
    localparam int DIV_W      = 80;  // dividend / quotient shift register
    localparam int ROOT_W     = 40;
    localparam int SREM_W     = 42;  // root remainder
    localparam int SU_W       = 44;  // shared subtractor operand width
    localparam int CNT_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CNT_W-1:0] DIV_LAST_STEP  = CNT_W'(DIV_W - 1);
    localparam logic [CNT_W-1:0] SQRT_LAST_STEP = CNT_W'(ROOT_W - 1);

    localparam logic [RES_W-1:0] RESULT_MAX = '1;
    localparam logic [SUM_W-1:0] SUM_MAX    = '1;
    localparam logic [TS_W-1:0]  TS_RESET   = TS_W'(65536);

    localparam logic [CFG_IDX_W-1:0] REG_TIME_SPAN = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_VOL_MODE  = CFG_IDX_W'(1);

    typedef struct packed {
        logic start;
        logic vol_mode;
    } rvv_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } rvv_stat_t;

endpackage

### design/rvv_div_sqrt.sv
// Bit-serial divide and square root engine around one shared subtractor.
`timescale 1ns / 1ps

module rvv_div_sqrt import rvv_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  rvv_req_t          req,
    input  logic [SUM_W-1:0]  sum,
    input  logic [TS_W-1:0]   time_span,
    output rvv_stat_t         stat,
    output logic [RES_W-1:0]  result,
    output logic              clamped
);

    typedef enum logic [1:0] {
        E_IDLE,
        E_DIV,
        E_SQRT,
        E_DONE
    } eng_state_t;

    eng_state_t          state_reg;
    logic                vol_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [DIV_W-1:0]    work_reg;
    logic [TS_W-1:0]     rem_reg;
    logic [SREM_W-1:0]   srem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [RES_W-1:0]    result_reg;
    logic                clamped_reg;

    logic [TS_W:0]       rem_sh;
    logic [SU_W-1:0]     srem_sh;
    logic [SU_W-1:0]     su_a;
    logic [SU_W-1:0]     su_b;
    logic [SU_W:0]       su_diff;
    logic                su_ge;
    logic [DIV_W-1:0]    quot_next;
    logic [ROOT_W-1:0]   root_next;

    always_comb begin
        rem_sh  = {rem_reg, work_reg[DIV_W-1]};
        srem_sh = {srem_reg, work_reg[DIV_W-1 -: 2]};
        unique case (state_reg)
            E_DIV: begin
                su_a = SU_W'(rem_sh);
                su_b = SU_W'(time_span);
            end
            E_SQRT: begin
                su_a = srem_sh;
                su_b = SU_W'({root_reg, 2'b01});
            end
            default: begin
                su_a = '0;
                su_b = '0;
            end
        endcase
        // the one subtract/compare shared by both iterations
        su_diff   = {1'b0, su_a} - {1'b0, su_b};
        su_ge     = !su_diff[SU_W];
        quot_next = {work_reg[DIV_W-2:0], su_ge};
        root_next = {root_reg[ROOT_W-2:0], su_ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= E_IDLE;
            cnt_reg     <= '0;
            vol_reg     <= 1'b0;
            clamped_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                E_IDLE: begin
                    if (req.start) begin
                        vol_reg   <= req.vol_mode;
                        work_reg  <= req.vol_mode ? {sum, 16'b0} : {16'b0, sum};
                        rem_reg   <= '0;
                        cnt_reg   <= DIV_LAST_STEP;
                        state_reg <= E_DIV;
                    end
                end
                E_DIV: begin
                    rem_reg  <= su_ge ? su_diff[TS_W-1:0] : rem_sh[TS_W-1:0];
                    work_reg <= quot_next;
                    if (cnt_reg == '0) begin
                        if (vol_reg) begin
                            srem_reg  <= '0;
                            root_reg  <= '0;
                            cnt_reg   <= SQRT_LAST_STEP;
                            state_reg <= E_SQRT;
                        end else begin
                            // quotient above 48 bits clamps
                            if (|quot_next[DIV_W-1:RES_W]) begin
                                result_reg  <= RESULT_MAX;
                                clamped_reg <= 1'b1;
                            end else begin
                                result_reg  <= quot_next[RES_W-1:0];
                                clamped_reg <= 1'b0;
                            end
                            state_reg <= E_DONE;
                        end
                    end else begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                E_SQRT: begin
                    srem_reg <= su_ge ? su_diff[SREM_W-1:0] : srem_sh[SREM_W-1:0];
                    root_reg <= root_next;
                    work_reg <= {work_reg[DIV_W-3:0], 2'b00};
                    cnt_reg  <= cnt_reg - 1'b1;
                    if (cnt_reg == '0) begin
                        result_reg  <= RES_W'(root_next);
                        clamped_reg <= 1'b0;
                        state_reg   <= E_DONE;
                    end
                end
                E_DONE: begin
                    state_reg <= E_IDLE;
                end
                default: begin
                    state_reg <= E_IDLE;
                end
            endcase
        end
    end

    assign stat.busy = (state_reg != E_IDLE);
    assign stat.done = (state_reg == E_DONE);
    assign result    = result_reg;
    assign clamped   = clamped_reg;

endmodule

### design/realized_variance_volatility_unit.sv
// Top level: sample stream in, squared-difference accumulation, path result out.
// A sample that is not last passes the accept, multiply and accumulate steps.
// A last sample adds a finish step, then runs the bit-serial divider for variance, or
// the divider and root for volatility, which share one subtractor.
// A zero sum or a zero time span skips the engine and goes from the finish step to emit.
// Reset (synchronous, active low) clears the path state and output; time_span = 1.0.
`timescale 1ns / 1ps

module realized_variance_volatility_unit import rvv_pkg::*; #(
    parameter int  SAMPLE_WIDTH = 32,
    localparam int S_TDATA_W    = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // slave stream
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [S_TDATA_W-1:0]    s_axis_tdata,   // sample
    input  logic                    s_axis_tlast,   // last_sample
    // master stream
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [RES_W-1:0]        m_axis_tdata,   // path_result
    output logic                    m_axis_tuser,   // overflowed
    // configuration writes
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    localparam int MW = SAMPLE_WIDTH + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_FIN,
        S_WAIT,
        S_EMIT
    } state_t;

    state_t                     state_reg;
    logic [TS_W-1:0]            time_span_reg;
    logic                       vol_mode_reg;
    logic [SAMPLE_WIDTH-1:0]    prev_reg;
    logic                       have_prev_reg;
    logic [SUM_W-1:0]           sum_reg;
    logic                       sum_sat_reg;
    logic [MAG_W-1:0]           mag_reg;
    logic                       big_reg;
    logic                       do_acc_reg;
    logic                       last_reg;
    logic [SUM_W-1:0]           prod_reg;
    logic [RES_W-1:0]           res_reg;
    logic                       ovf_reg;
    logic                       m_valid_reg;
    logic [RES_W-1:0]           m_data_reg;
    logic                       m_user_reg;

    logic [SAMPLE_WIDTH-1:0]    sample_in;
    logic signed [MW-1:0]       diff;
    logic [MW-1:0]              mag;
    logic [63:0]                mag_ext;
    logic [SUM_W-1:0]           sq;
    logic [SUM_W:0]             sum_add;
    logic [SUM_W-1:0]           sum_next;
    logic                       sat_next;
    logic                       s_accept;
    logic                       out_free;

    rvv_req_t                   eng_req;
    rvv_stat_t                  eng_stat;
    logic [RES_W-1:0]           eng_result;
    logic                       eng_clamped;

    always_comb begin
        sample_in = s_axis_tdata[SAMPLE_WIDTH-1:0];
        diff      = $signed({sample_in[SAMPLE_WIDTH-1], sample_in})
                  - $signed({prev_reg[SAMPLE_WIDTH-1], prev_reg});
        mag       = diff[MW-1] ? MW'(-diff) : MW'(diff);
        mag_ext   = 64'(mag);

        sq        = big_reg ? SUM_MAX : prod_reg;
        sum_add   = {1'b0, sum_reg} + {1'b0, sq};
        sum_next  = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
        sat_next  = sum_sat_reg | big_reg | sum_add[SUM_W];
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign cfg_ready     = 1'b1;

    assign eng_req.start    = (state_reg == S_FIN) && (sum_reg != '0) && (time_span_reg != '0);
    assign eng_req.vol_mode = vol_mode_reg;

    rvv_div_sqrt u_div_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (eng_req),
        .sum       (sum_reg),
        .time_span (time_span_reg),
        .stat      (eng_stat),
        .result    (eng_result),
        .clamped   (eng_clamped)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            time_span_reg <= TS_RESET;
            vol_mode_reg  <= 1'b0;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            sum_reg       <= '0;
            sum_sat_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                priority if (cfg_index == REG_TIME_SPAN) begin
                    time_span_reg <= cfg_data[TS_W-1:0];
                end else if (cfg_index == REG_VOL_MODE) begin
                    vol_mode_reg <= cfg_data[0];
                end
            end

            priority if ((state_reg == S_EMIT) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        mag_reg       <= mag_ext[MAG_W-1:0];
                        big_reg       <= |mag_ext[63:MAG_W];
                        do_acc_reg    <= have_prev_reg;
                        last_reg      <= s_axis_tlast;
                        prev_reg      <= sample_in;
                        have_prev_reg <= 1'b1;
                        state_reg     <= S_MUL;
                    end
                end
                S_MUL: begin
                    prod_reg  <= mag_reg * mag_reg;
                    state_reg <= S_ACC;
                end
                S_ACC: begin
                    if (do_acc_reg) begin
                        sum_reg     <= sum_next;
                        sum_sat_reg <= sat_next;
                    end
                    state_reg <= last_reg ? S_FIN : S_IDLE;
                end
                S_FIN: begin
                    priority if (sum_reg == '0) begin
                        res_reg   <= '0;
                        ovf_reg   <= sum_sat_reg;
                        state_reg <= S_EMIT;
                    end else if (time_span_reg == '0) begin
                        res_reg   <= RESULT_MAX;
                        ovf_reg   <= 1'b1;
                        state_reg <= S_EMIT;
                    end else begin
                        state_reg <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (eng_stat.done) begin
                        res_reg   <= eng_result;
                        ovf_reg   <= sum_sat_reg | eng_clamped;
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        m_data_reg    <= res_reg;
                        m_user_reg    <= ovf_reg;
                        prev_reg      <= '0;
                        have_prev_reg <= 1'b0;
                        sum_reg       <= '0;
                        sum_sat_reg   <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // a saturated sum is always pinned at full scale
    a_sat_pins_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        sum_sat_reg |-> (sum_reg == SUM_MAX))
        else $error("saturated sum not at full scale");

    // the engine runs only while the sequencer waits on it
    a_engine_owned: assert property (@(posedge aclk) disable iff (!aresetn)
        eng_stat.busy |-> (state_reg == S_WAIT))
        else $error("engine busy outside wait state");

    // the engine is only started with a nonzero divisor and sum
    a_start_operands: assert property (@(posedge aclk) disable iff (!aresetn)
        eng_req.start |-> (time_span_reg != '0) && (sum_reg != '0))
        else $error("engine started with zero operand");

    // a result transaction clears the path state
    a_emit_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT) && out_free |=> !have_prev_reg && (sum_reg == '0))
        else $error("path state not cleared after result");

endmodule
